// ----- design/ltc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants of the timeline clock
// Field widths, play mode and opcode codes, register indexes and the status
// struct between the top level and the serial divider.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int TIME_W  = 31;
    localparam int ABS_W   = 32;
    localparam int CNT_W   = $clog2(TIME_W);
    localparam int CFG_W   = TIME_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_ONCE      = 2'd0,
        MODE_LOOP      = 2'd1,
        MODE_PONG      = 2'd2,
        MODE_PONG_ONCE = 2'd3
    } play_mode_t;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEEK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/ltc_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_ifs: handshake channels of the timeline clock
// Command channel (tick or seek beats) and result channel (displayed time).
// ----------------------------------------------------------------------------
interface ltc_cmd_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] absolute_time;
    logic [30:0] seek_time;

    modport source (output valid, opcode, absolute_time, seek_time, input ready);
    modport sink   (input valid, opcode, absolute_time, seek_time, output ready);
endinterface

interface ltc_res_if;
    logic        valid;
    logic        ready;
    logic [30:0] current_time;
    logic        reached_end;

    modport source (output valid, current_time, reached_end, input ready);
    modport sink   (input valid, current_time, reached_end, output ready);
endinterface

// ----- design/ltc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_div: serial restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module ltc_div
    import ltc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output div_stat_t         stat,
    output logic [TIME_W-1:0] quotient,
    output logic [TIME_W-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0] dsr_reg, dsr_next;

    logic [TIME_W:0]   rem_shift;
    logic [TIME_W+1:0] diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[TIME_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the difference when no borrow, else restore
            if (!diff[TIME_W+1])
            begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/looping_playback_timeline_clock.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_playback_timeline_clock: looping / ping-pong playback timer
// Advances a virtual time by absolute timer deltas and maps it to a
// displayed position according to the play mode.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one beat per tick or seek. A tick beat adds the wrapped
//   difference of absolute_time from the previous reading to the virtual
//   time (saturating at 2^31-1) and yields one beat on res. A seek beat
//   loads last reading and virtual time and yields nothing.
//   A seek completes in the accept step. A tick in play-once mode, or
//   with end_time 0, runs the accept, add and finish steps. A tick in loop
//   or ping-pong modes runs accept, add, the 31-step serial divider (one
//   quotient bit per cycle) and finish.
//   cmd.ready is high only while the sequencer is idle.
//   The result sits in an output register: the next beat is accepted while
//   it waits. When res stalls with a result still held, a following tick
//   holds in the finish step until the register frees up.
//   Config (cfg_we, cfg_index, cfg_data) is to be written only while idle, by
//   the user; the block does not enforce it. Index 0 is end_time, index 1 is play_mode.
//   Reset clears both registers, last reading and virtual time to zero and
//   empties the output register.
// ----------------------------------------------------------------------------
module looping_playback_timeline_clock
    import ltc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ltc_cmd_if.sink              cmd,
    ltc_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] end_time_reg, end_time_next;
    play_mode_t        play_mode_reg, play_mode_next;
    logic [ABS_W-1:0]  last_reg, last_next;
    logic [TIME_W-1:0] virt_reg, virt_next;
    logic [ABS_W-1:0]  delta_reg, delta_next;
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic              out_end_reg, out_end_next;

    logic [ABS_W:0]    sum;
    logic [TIME_W-1:0] sat_time;
    logic              div_start;
    div_stat_t         div_stat;
    logic [TIME_W-1:0] div_quo;
    logic [TIME_W-1:0] div_rem;
    logic              cmd_fire;
    logic              emit;
    logic [TIME_W-1:0] res_time;
    logic              res_end;

    // divider: quotient and remainder of virtual time by end time
    ltc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sat_time),
        .divisor   (end_time_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign cmd_fire = cmd.valid && cmd.ready;

    // saturating advance of the virtual time
    assign sum      = {2'b00, virt_reg} + {1'b0, delta_reg};
    assign sat_time = (|sum[ABS_W:TIME_W]) ? TIME_MAX : sum[TIME_W-1:0];

    assign div_start = (state_reg == ST_ADD) && (end_time_reg != '0)
                       && (play_mode_reg != MODE_ONCE);

    // result mapping, evaluated in the finish step
    always_comb
    begin
        res_time = '0;
        res_end  = 1'b0;
        if (end_time_reg == '0)
        begin
            res_end = 1'b1;
        end
        else
        begin
            case (play_mode_reg)
                MODE_ONCE:
                begin
                    res_time = virt_reg;
                    res_end  = (virt_reg >= end_time_reg);
                end
                MODE_LOOP:
                begin
                    res_time = div_rem;
                end
                MODE_PONG, MODE_PONG_ONCE:
                begin
                    if (play_mode_reg == MODE_PONG_ONCE && (|div_quo[TIME_W-1:1]))
                    begin
                        // past the second pass: park at zero
                        res_time = '0;
                    end
                    else if (div_quo[0])
                    begin
                        // backward pass; at the boundary this lands on end
                        res_time = end_time_reg - div_rem;
                        res_end  = (div_rem == '0);
                    end
                    else
                    begin
                        res_time = div_rem;
                    end
                end
                default:
                begin
                    res_time = '0;
                end
            endcase
        end
    end

    assign emit = (state_reg == ST_FIN) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next     = state_reg;
        end_time_next  = end_time_reg;
        play_mode_next = play_mode_reg;
        last_next      = last_reg;
        virt_next      = virt_reg;
        delta_next     = delta_reg;
        out_valid_next = out_valid_reg;
        out_time_next  = out_time_reg;
        out_end_next   = out_end_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_END_TIME:  end_time_next  = cfg_data[TIME_W-1:0];
                CFG_PLAY_MODE: play_mode_next = play_mode_t'(cfg_data[1:0]);
                default:       end_time_next  = end_time_reg;
            endcase
        end

        // drop the held result once the sink takes it
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    last_next = cmd.absolute_time;
                    if (cmd.opcode == OP_SEEK)
                    begin
                        virt_next = cmd.seek_time;
                    end
                    else
                    begin
                        delta_next = cmd.absolute_time - last_reg;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                virt_next  = sat_time;
                state_next = div_start ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // loop mode folds the remainder back into virtual time
                    if (play_mode_reg == MODE_LOOP)
                    begin
                        virt_next = div_rem;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = res_time;
                    out_end_next   = res_end;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            end_time_reg  <= '0;
            play_mode_reg <= MODE_ONCE;
            last_reg      <= '0;
            virt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_time_reg  <= end_time_next;
            play_mode_reg <= play_mode_next;
            last_reg      <= last_next;
            virt_reg      <= virt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg    <= delta_next;
        out_time_reg <= out_time_next;
        out_end_reg  <= out_end_next;
    end

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.current_time = out_time_reg;
    assign res.reached_end  = out_end_reg;

    // a new result only ever comes out of the finish step
    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the finish step");

    // the divider reports completion only while the sequencer waits on it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider done outside the divide step");

    // no new command while the divider is still stepping
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !div_stat.busy)
        else $error("command accepted while divider busy");

    // loop mode never reports the end for a nonzero end time
    a_loop_no_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && play_mode_reg == MODE_LOOP && end_time_reg != '0) |=> !out_end_reg)
        else $error("loop mode flagged end");

endmodule

// ----- tb/sv/tb_looping_playback_timeline_clock.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_looping_playback_timeline_clock: self-checking bench of the timeline clock
// Drives tick and seek beats under random back-pressure on both channels.
// A scoreboard tracks the virtual time and play mode on its own, predicts
// every displayed position and compares it field by field on the result
// channel. Directed beats cover the corner cases first, then random phases
// sweep all play modes over tiny, small, large and maximal end times, then a zero one.
// ----------------------------------------------------------------------------
module tb_looping_playback_timeline_clock;
    import ltc_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 17;
    localparam int PHASE_BEATS   = 65;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [TIME_W-1:0] position;
        logic              at_end;
    } position_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers and timeline state, plus the
    // queue of positions still owed by the block.
    // ------------------------------------------------------------------------
    class timeline_scoreboard;
        logic [TIME_W-1:0] end_time;
        play_mode_t        mode;
        logic [ABS_W-1:0]  last_reading;
        logic [TIME_W-1:0] vtime;
        position_t         owed_q[$];
        int                errors;

        function new();
            end_time     = '0;
            mode         = MODE_ONCE;
            last_reading = '0;
            vtime        = '0;
            errors       = 0;
        endfunction

        function void set_config(logic [TIME_W-1:0] span, play_mode_t m);
            end_time = span;
            mode     = m;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Note one accepted command beat and queue the position it yields.
        function void note_beat(logic op, logic [ABS_W-1:0] abs_t,
                                logic [TIME_W-1:0] seek_t);
            logic [ABS_W-1:0]  delta;
            logic [ABS_W:0]    sum;
            logic [TIME_W-1:0] q;
            logic [TIME_W-1:0] r;
            logic [TIME_W-1:0] pos;
            position_t         res;
            if (op == OP_SEEK)
            begin
                last_reading = abs_t;
                vtime        = seek_t;
                return;
            end
            delta        = abs_t - last_reading;
            last_reading = abs_t;
            sum          = {2'b00, vtime} + {1'b0, delta};
            vtime        = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
            if (end_time == '0)
            begin
                res.position = '0;
                res.at_end   = 1'b1;
                owed_q.push_back(res);
                return;
            end
            case (mode)
                MODE_ONCE: pos = vtime;
                MODE_LOOP:
                begin
                    pos   = vtime % end_time;
                    vtime = pos;
                end
                default:
                begin
                    q = vtime / end_time;
                    r = vtime % end_time;
                    if (mode == MODE_PONG_ONCE && q > 1)
                        pos = '0;
                    else if (q[0])
                        pos = end_time - r;
                    else
                        pos = r;
                end
            endcase
            res.position = pos;
            res.at_end   = (pos >= end_time);
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [TIME_W-1:0] pos, logic at_end);
            position_t exp_res;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result beat: current_time %0d, reached_end %0d",
                       pos, at_end);
                errors++;
                return;
            end
            exp_res = owed_q.pop_front();
            if (pos !== exp_res.position)
            begin
                $error("current_time mismatch: expected %0d, actual %0d",
                       exp_res.position, pos);
                errors++;
            end
            if (at_end !== exp_res.at_end)
            begin
                $error("reached_end mismatch: expected %0d, actual %0d",
                       exp_res.at_end, at_end);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    ltc_cmd_if cmd_if ();
    ltc_res_if res_if ();

    timeline_scoreboard sb = new();

    // Handshake knobs of the sender and the receiver.
    bit sender_jitter;
    bit receiver_jitter;
    bit hold_req;

    logic [ABS_W-1:0] abs_now;
    int               cycles;

    looping_playback_timeline_clock dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Abort the run if it never completes.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** looping_playback_timeline_clock: FAILED **");
            $finish;
        end
    end

    // Receiver: drop ready in short random bursts, or for one long stretch on
    // request so the output register fills and the command side stalls.
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                res_if.ready <= 1'b0;
            end
            else if (receiver_jitter && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Check every result beat against the oldest owed position.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            sb.check_result(res_if.current_time, res_if.reached_end);
    end

    // Hold the command channel idle until every owed result is in, then let
    // a seek or a result-less tail finish inside the block.
    task automatic settle_idle();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle.
    task automatic write_timeline_regs(input logic [TIME_W-1:0] span, input play_mode_t m);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_END_TIME;
        cfg_data  <= CFG_W'(span);
        @(posedge clk);
        cfg_index <= CFG_PLAY_MODE;
        cfg_data  <= CFG_W'(m);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_config(span, m);
    endtask

    // Offer one command beat, optionally after a random gap, and hold it
    // until the block takes it.
    task automatic send_beat(input logic op, input logic [ABS_W-1:0] abs_t,
                             input logic [TIME_W-1:0] seek_t);
        if (sender_jitter && $urandom_range(0, 5) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.opcode        <= op;
        cmd_if.absolute_time <= abs_t;
        cmd_if.seek_time     <= seek_t;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        sb.note_beat(op, abs_t, seek_t);
    endtask

    // Advance of the absolute timer between ticks: mostly on the scale of the
    // end time so the loop and ping-pong passes roll over, sometimes zero,
    // tiny, or a full 32-bit jump that wraps the timer or saturates.
    function automatic logic [ABS_W-1:0] pick_delta(logic [TIME_W-1:0] span);
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel < 3)
            return ABS_W'($urandom_range(1, 16));
        if (sel < 5)
            return ABS_W'($urandom());
        if (span == '0)
            return ABS_W'($urandom_range(0, 1000));
        return ABS_W'($urandom_range(0, span));
    endfunction

    // Seek target: extremes, fully random, or up to three end times in.
    function automatic logic [TIME_W-1:0] pick_seek_time(logic [TIME_W-1:0] span);
        int unsigned       sel;
        logic [TIME_W-1:0] lim;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return TIME_MAX;
        if (sel == 1)
            return '0;
        if (sel < 4 || span == '0)
            return TIME_W'($urandom());
        lim = (span > TIME_MAX / 3) ? TIME_MAX : span * 3;
        return TIME_W'($urandom_range(0, lim));
    endfunction

    initial
    begin
        logic [TIME_W-1:0] span;
        play_mode_t        m;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_END_TIME;
        cfg_data             <= '0;
        cmd_if.valid         <= 1'b0;
        cmd_if.opcode        <= OP_TICK;
        cmd_if.absolute_time <= '0;
        cmd_if.seek_time     <= '0;
        cycles               <= 0;
        sender_jitter   = 1'b1;
        receiver_jitter = 1'b1;
        hold_req        = 1'b0;
        abs_now         = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: registers at reset give end time zero, so a tick shows 0
        // with reached_end set.
        send_beat(OP_TICK, 32'd0, TIME_MAX);

        // Play once: below and past the end.
        write_timeline_regs(31'd100, MODE_ONCE);
        send_beat(OP_TICK, 32'd50, 31'd0);
        send_beat(OP_TICK, 32'd150, 31'd0);
        // Saturation across a wrap of the absolute timer.
        send_beat(OP_SEEK, 32'hFFFF_FFF0, TIME_MAX - 31'd5);
        send_beat(OP_TICK, 32'h0000_0010, 31'd0);

        // Loop: remainder is written back into the virtual time.
        write_timeline_regs(31'd100, MODE_LOOP);
        send_beat(OP_SEEK, 32'd0, 31'd0);
        send_beat(OP_TICK, 32'd250, 31'd0);
        send_beat(OP_TICK, 32'd350, 31'd0);
        send_beat(OP_TICK, 32'd400, 31'd0);

        // Ping-pong: backward pass, even boundary, odd boundary hits the end.
        write_timeline_regs(31'd100, MODE_PONG);
        send_beat(OP_SEEK, 32'd0, 31'd0);
        send_beat(OP_TICK, 32'd130, 31'd0);
        send_beat(OP_TICK, 32'd200, 31'd0);
        send_beat(OP_TICK, 32'd300, 31'd0);

        // Ping-pong once: position drops to zero after two passes.
        write_timeline_regs(31'd100, MODE_PONG_ONCE);
        send_beat(OP_SEEK, 32'd0, 31'd0);
        send_beat(OP_TICK, 32'd150, 31'd0);
        send_beat(OP_TICK, 32'd250, 31'd0);

        // Maximal end time with a maximal step.
        write_timeline_regs(TIME_MAX, MODE_ONCE);
        send_beat(OP_SEEK, 32'hFFFF_FFFF, 31'd0);
        send_beat(OP_TICK, 32'h7FFF_FFFE, 31'd0);

        // Zero end time in a ping-pong mode.
        write_timeline_regs(31'd0, MODE_PONG);
        send_beat(OP_TICK, 32'h8000_0000, 31'd0);
        abs_now = 32'h8000_0000;

        // Random phases: every mode against tiny, small, large and maximal
        // end times, then one with a zero end time.
        for (int p = 0; p < PHASES; p++)
        begin
            m = play_mode_t'(p % 4);
            case (p / 4)
                0: span = TIME_W'($urandom_range(1, 5000));
                1: span = TIME_W'($urandom_range(1, 2));
                2: span = TIME_W'($urandom_range(1 << 20, TIME_MAX));
                3: span = TIME_MAX;
                default:
                begin
                    span = '0;
                    m    = play_mode_t'($urandom_range(0, 3));
                end
            endcase
            write_timeline_regs(span, m);

            // Quiet tail: no idling on either side.
            if (p >= PHASES - 3)
            begin
                sender_jitter   = 1'b0;
                receiver_jitter = 1'b0;
            end
            // Starve the result side while commands keep coming.
            if (p == 5)
                hold_req = 1'b1;

            // Open with a seek so the phase starts from a known position.
            abs_now = $urandom();
            send_beat(OP_SEEK, abs_now, pick_seek_time(span));
            for (int i = 1; i < PHASE_BEATS; i++)
            begin
                // Pause the sender mid-phase until the result side catches up.
                if (p == 9 && i == PHASE_BEATS / 2)
                    settle_idle();
                if ($urandom_range(0, 9) == 0)
                begin
                    abs_now = $urandom();
                    send_beat(OP_SEEK, abs_now, pick_seek_time(span));
                end
                else
                begin
                    abs_now = abs_now + pick_delta(span);
                    send_beat(OP_TICK, abs_now, TIME_W'($urandom()));
                end
            end
        end

        settle_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** looping_playback_timeline_clock: PASSED **");
        else
            $display("** looping_playback_timeline_clock: FAILED **");
        $finish;
    end

endmodule
